// ===== rtl/fssl_pkg.sv =====
// Shared types, widths and constants for the four-servo slew-limited steering block.
`timescale 1ns / 1ps

package fssl_pkg;

  localparam int unsigned NSERVO  = 4;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned GAIN_W  = 4;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned FILTER_FRAC_BITS = 8;
  localparam int unsigned FILT_W  = 24;
  localparam int unsigned DUTY_W  = 14;
  localparam int unsigned ANG_W   = 13;
  localparam int unsigned CLIP_W  = 9;
  localparam int unsigned TGT_W   = 21;
  localparam int unsigned TSUM_W  = 27;

  localparam int unsigned SUM_W   = 30;
  localparam int unsigned QUO_W   = SUM_W - 3;
  localparam int unsigned DIV5_SH = QUO_W + 3;
  localparam int unsigned PROD5_W = 2 * QUO_W + 1;

  localparam int unsigned MAG_W   = IN_W + 1;
  localparam int unsigned DIV7_SH = 18;
  localparam int unsigned Q7_W    = MAG_W - 2;
  localparam int unsigned PROD7_W = MAG_W + 16;

  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [IN_W-1:0]   in_t;
  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic signed [DUTY_W-1:0] duty_t;
  typedef logic [ANG_W-1:0]         angmag_t;
  typedef logic signed [FILT_W-1:0] filt_t;
  typedef logic signed [TGT_W-1:0]  tgt_t;
  typedef logic [CLIP_W-1:0]        clip_t;
  typedef logic [QUO_W:0]           recip5_t;
  typedef logic [15:0]              recip7_t;

  localparam recip5_t RECIP5 = recip5_t'(((64'd1 << DIV5_SH) + 64'd4) / 64'd5);
  localparam recip7_t RECIP7 = recip7_t'(((64'd1 << DIV7_SH) + 64'd6) / 64'd7);

  localparam clip_t SPEED_LIM = clip_t'(350);
  localparam clip_t ANGLE_LIM = clip_t'(280);
  localparam int    STEP_LIM  = 5;

  localparam pos_t POSITION_MIN = pos_t'(2000);
  localparam pos_t POSITION_MAX = pos_t'(6000);
  localparam pos_t CENTER_RST   = pos_t'(4000);
  localparam logic [3:0] DIR_RST   = 4'd15;
  localparam gain_t      SPEED_RST = gain_t'(6);
  localparam gain_t      BOOST_RST = gain_t'(6);

  typedef enum logic [2:0] {
    REG_CENTER_A,
    REG_CENTER_B,
    REG_CENTER_C,
    REG_CENTER_D,
    REG_DIR_MASK,
    REG_SPEED_GAIN,
    REG_BOOST_GAIN
  } reg_idx_e;

  typedef struct packed {
    pos_t [NSERVO-1:0]  center;
    logic [NSERVO-1:0]  dir_mask;
    gain_t              speed_gain;
    gain_t              boost_gain;
  } cfg_t;

  typedef struct packed {
    logic run;
    logic jump;
    logic hold;
  } mode_t;

endpackage

// ===== rtl/fssl_cfg.sv =====
// APB register file holding servo centers, direction mask and gains.
`timescale 1ns / 1ps

module fssl_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fssl_pkg::ADDR_W-1:0] paddr,
  input  logic [fssl_pkg::DATA_W-1:0] pwdata,
  output logic [fssl_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output fssl_pkg::cfg_t              cfg_o
);

  localparam int unsigned ADDR_HI = fssl_pkg::ADDR_W - 1;

  fssl_pkg::cfg_t     cfg_q;
  fssl_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = fssl_pkg::reg_idx_e'(paddr[ADDR_HI:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center     <= {fssl_pkg::NSERVO{fssl_pkg::CENTER_RST}};
      cfg_q.dir_mask   <= fssl_pkg::DIR_RST;
      cfg_q.speed_gain <= fssl_pkg::SPEED_RST;
      cfg_q.boost_gain <= fssl_pkg::BOOST_RST;
    end else if (wr_en) begin
      case (idx)
        fssl_pkg::REG_CENTER_A:   cfg_q.center[0]  <= pwdata[fssl_pkg::POS_W-1:0];
        fssl_pkg::REG_CENTER_B:   cfg_q.center[1]  <= pwdata[fssl_pkg::POS_W-1:0];
        fssl_pkg::REG_CENTER_C:   cfg_q.center[2]  <= pwdata[fssl_pkg::POS_W-1:0];
        fssl_pkg::REG_CENTER_D:   cfg_q.center[3]  <= pwdata[fssl_pkg::POS_W-1:0];
        fssl_pkg::REG_DIR_MASK:   cfg_q.dir_mask   <= pwdata[fssl_pkg::NSERVO-1:0];
        fssl_pkg::REG_SPEED_GAIN: cfg_q.speed_gain <= pwdata[fssl_pkg::GAIN_W-1:0];
        fssl_pkg::REG_BOOST_GAIN: cfg_q.boost_gain <= pwdata[fssl_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      fssl_pkg::REG_CENTER_A:   prdata = fssl_pkg::DATA_W'(cfg_q.center[0]);
      fssl_pkg::REG_CENTER_B:   prdata = fssl_pkg::DATA_W'(cfg_q.center[1]);
      fssl_pkg::REG_CENTER_C:   prdata = fssl_pkg::DATA_W'(cfg_q.center[2]);
      fssl_pkg::REG_CENTER_D:   prdata = fssl_pkg::DATA_W'(cfg_q.center[3]);
      fssl_pkg::REG_DIR_MASK:   prdata = fssl_pkg::DATA_W'(cfg_q.dir_mask);
      fssl_pkg::REG_SPEED_GAIN: prdata = fssl_pkg::DATA_W'(cfg_q.speed_gain);
      fssl_pkg::REG_BOOST_GAIN: prdata = fssl_pkg::DATA_W'(cfg_q.boost_gain);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== rtl/fssl_cond.sv =====
// Input conditioning: speed divide by seven, clamp and gain; angle clamp, gain and split.
`timescale 1ns / 1ps

module fssl_cond (
  input  logic                  clk_i,
  input  logic                  adv_i,
  input  fssl_pkg::in_t         spd_i,
  input  fssl_pkg::in_t         ang_i,
  input  logic                  boost_i,
  input  logic                  jump_i,
  input  fssl_pkg::gain_t       speed_gain_i,
  input  fssl_pkg::gain_t       boost_gain_i,
  output fssl_pkg::duty_t       duty_o,
  output fssl_pkg::angmag_t     neg_o,
  output fssl_pkg::angmag_t     pos_o
);

  localparam int unsigned MAG_W = fssl_pkg::MAG_W;

  logic                          spd_neg;
  logic [MAG_W-1:0]              spd_mag;
  logic [fssl_pkg::PROD7_W-1:0]  q7_prod;
  logic [fssl_pkg::Q7_W-1:0]     q7;
  fssl_pkg::clip_t               spd_clip;
  logic                          ang_neg;
  logic [MAG_W-1:0]              ang_mag;
  fssl_pkg::clip_t               ang_clip;
  fssl_pkg::gain_t               ang_gain;
  fssl_pkg::angmag_t             ang_prod;
  fssl_pkg::angmag_t             neg_d;
  fssl_pkg::angmag_t             pos_d;
  fssl_pkg::angmag_t             duty_mag;
  fssl_pkg::duty_t               duty_d;

  logic                          spd_neg_q;
  fssl_pkg::clip_t               spd_clip_q;
  fssl_pkg::angmag_t             neg1_q;
  fssl_pkg::angmag_t             pos1_q;
  fssl_pkg::duty_t               duty_q;
  fssl_pkg::angmag_t             neg2_q;
  fssl_pkg::angmag_t             pos2_q;

  always_comb begin
    spd_neg  = spd_i[fssl_pkg::IN_W-1];
    spd_mag  = spd_neg ? (MAG_W'(0) - {spd_i[fssl_pkg::IN_W-1], spd_i})
                       : {1'b0, spd_i};
    q7_prod  = fssl_pkg::PROD7_W'(spd_mag) * fssl_pkg::PROD7_W'(fssl_pkg::RECIP7);
    q7       = q7_prod[fssl_pkg::DIV7_SH +: fssl_pkg::Q7_W];
    spd_clip = (q7 > fssl_pkg::Q7_W'(fssl_pkg::SPEED_LIM)) ? fssl_pkg::SPEED_LIM
                                                         : q7[fssl_pkg::CLIP_W-1:0];

    ang_neg  = ang_i[fssl_pkg::IN_W-1];
    ang_mag  = ang_neg ? (MAG_W'(0) - {ang_i[fssl_pkg::IN_W-1], ang_i})
                       : {1'b0, ang_i};
    ang_clip = (ang_mag > MAG_W'(fssl_pkg::ANGLE_LIM)) ? fssl_pkg::ANGLE_LIM
                                                      : ang_mag[fssl_pkg::CLIP_W-1:0];
    ang_gain = boost_i ? boost_gain_i : fssl_pkg::gain_t'(1);
    ang_prod = fssl_pkg::ANG_W'(ang_clip) * fssl_pkg::ANG_W'(ang_gain);
    neg_d    = (!jump_i && ang_neg)  ? ang_prod : '0;
    pos_d    = (!jump_i && !ang_neg) ? ang_prod : '0;
  end

  always_comb begin
    duty_mag = fssl_pkg::ANG_W'(spd_clip_q) * fssl_pkg::ANG_W'(speed_gain_i);
    duty_d   = spd_neg_q ? (fssl_pkg::DUTY_W'(0) - fssl_pkg::DUTY_W'(duty_mag))
                         : fssl_pkg::DUTY_W'(duty_mag);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      spd_neg_q  <= spd_neg;
      spd_clip_q <= spd_clip;
      neg1_q     <= neg_d;
      pos1_q     <= pos_d;
      duty_q     <= duty_d;
      neg2_q     <= neg1_q;
      pos2_q     <= pos1_q;
    end
  end

  assign duty_o = duty_q;
  assign neg_o  = neg2_q;
  assign pos_o  = pos2_q;

endmodule

// ===== rtl/fssl_filt.sv =====
// Speed low-pass filter at 19/20 in signed fixed point, truncated toward zero.
`timescale 1ns / 1ps

module fssl_filt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  fssl_pkg::duty_t  duty_i,
  output fssl_pkg::filt_t  filt_o
);

  localparam int unsigned SUM_W  = fssl_pkg::SUM_W;
  localparam int unsigned FILT_W = fssl_pkg::FILT_W;
  localparam int unsigned DUTY_W = fssl_pkg::DUTY_W;
  localparam int unsigned FRAC   = fssl_pkg::FILTER_FRAC_BITS;

  fssl_pkg::filt_t              filt_q;
  fssl_pkg::filt_t              filt_d;
  logic signed [SUM_W-1:0]      fx;
  logic signed [SUM_W-1:0]      dx;
  logic signed [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]             sum_u;
  logic [SUM_W-1:0]             mag;
  logic [fssl_pkg::QUO_W-1:0]   quo_in;
  logic [fssl_pkg::PROD5_W-1:0] prod;
  logic [FILT_W-1:0]            quo;

  always_comb begin
    fx     = {{(SUM_W - FILT_W){filt_q[FILT_W-1]}}, filt_q};
    dx     = {{(SUM_W - DUTY_W - FRAC){duty_i[DUTY_W-1]}}, duty_i, {FRAC{1'b0}}};
    sum    = (fx <<< 4) + (fx <<< 1) + fx + dx;
    sum_u  = sum;
    mag    = sum_u[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;
    quo_in = mag[SUM_W-2:2];
    prod   = fssl_pkg::PROD5_W'(quo_in) * fssl_pkg::PROD5_W'(fssl_pkg::RECIP5);
    quo    = prod[fssl_pkg::DIV5_SH +: FILT_W];
    filt_d = sum_u[SUM_W-1] ? (FILT_W'(0) - quo) : quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= '0;
    end else if (adv_i && valid_i) begin
      filt_q <= filt_d;
    end
  end

  assign filt_o = filt_q;

endmodule

// ===== rtl/fssl_servo.sv =====
// One servo: target offset from the filter, slew-limited move or centering step, clamp.
`timescale 1ns / 1ps

module fssl_servo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  fssl_pkg::mode_t   mode_i,
  input  fssl_pkg::filt_t   filt_i,
  input  logic              neg_f_i,
  input  fssl_pkg::angmag_t k_i,
  input  fssl_pkg::pos_t    ctr_i,
  input  logic              dir_i,
  output fssl_pkg::pos_t    pos_o
);

  localparam int unsigned TSUM_W = fssl_pkg::TSUM_W;
  localparam int unsigned FILT_W = fssl_pkg::FILT_W;
  localparam int unsigned TGT_W  = fssl_pkg::TGT_W;
  localparam int unsigned ANG_W  = fssl_pkg::ANG_W;
  localparam int unsigned POS_W  = fssl_pkg::POS_W;
  localparam int unsigned FRAC   = fssl_pkg::FILTER_FRAC_BITS;
  localparam int unsigned ERR_W  = TGT_W + 1;
  localparam int unsigned NP_W   = POS_W + 2;

  localparam logic signed [TSUM_W-1:0] FRAC_BIAS = TSUM_W'((1 << FRAC) - 1);
  localparam logic signed [ERR_W-1:0]  STEP_HI   = ERR_W'(fssl_pkg::STEP_LIM);
  localparam logic signed [ERR_W-1:0]  STEP_LO   = -ERR_W'(fssl_pkg::STEP_LIM);
  localparam logic signed [NP_W-1:0]   LIM_LO    = NP_W'(fssl_pkg::POSITION_MIN);
  localparam logic signed [NP_W-1:0]   LIM_HI    = NP_W'(fssl_pkg::POSITION_MAX);

  fssl_pkg::pos_t             pos_q;
  fssl_pkg::pos_t             pos_d;
  logic signed [TSUM_W-1:0]   fx;
  logic signed [TSUM_W-1:0]   kx;
  logic signed [TSUM_W-1:0]   tsum;
  logic signed [TSUM_W-1:0]   tshift;
  fssl_pkg::tgt_t             target;
  logic signed [NP_W-1:0]     diff;
  logic signed [NP_W-1:0]     loc;
  logic signed [ERR_W-1:0]    tgt_x;
  logic signed [ERR_W-1:0]    loc_x;
  logic signed [ERR_W-1:0]    err;
  logic signed [3:0]          mv;
  logic signed [3:0]          step;
  logic signed [3:0]          step_ctr;
  logic signed [3:0]          delta;
  logic signed [NP_W-1:0]     npos;
  fssl_pkg::pos_t             clamped;

  always_comb begin
    fx     = {{(TSUM_W - FILT_W){filt_i[FILT_W-1]}}, filt_i};
    if (neg_f_i) begin
      fx = -fx;
    end
    kx     = {{(TSUM_W - ANG_W - FRAC){1'b0}}, k_i, {FRAC{1'b0}}};
    tsum   = fx + kx;
    tshift = (tsum + (tsum[TSUM_W-1] ? FRAC_BIAS : TSUM_W'(0))) >>> FRAC;
    target = tshift[TGT_W-1:0];

    diff  = {2'b00, pos_q} - {2'b00, ctr_i};
    loc   = dir_i ? diff : -diff;
    tgt_x = {target[TGT_W-1], target};
    loc_x = {{(ERR_W - NP_W){loc[NP_W-1]}}, loc};
    err   = tgt_x - loc_x;
    if (err > STEP_HI) begin
      mv = 4'(fssl_pkg::STEP_LIM);
    end else if (err < STEP_LO) begin
      mv = -4'(fssl_pkg::STEP_LIM);
    end else begin
      mv = err[3:0];
    end
    step = dir_i ? mv : -mv;

    if (diff < 0) begin
      step_ctr = 4'sd1;
    end else if (diff > 0) begin
      step_ctr = -4'sd1;
    end else begin
      step_ctr = 4'sd0;
    end

    delta = mode_i.run ? step : step_ctr;
    npos  = {2'b00, pos_q} + {{(NP_W - 4){delta[3]}}, delta};
    if (npos < LIM_LO) begin
      clamped = fssl_pkg::POSITION_MIN;
    end else if (npos > LIM_HI) begin
      clamped = fssl_pkg::POSITION_MAX;
    end else begin
      clamped = npos[POS_W-1:0];
    end

    pos_d = (mode_i.run && (mode_i.jump || mode_i.hold)) ? pos_q : clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= fssl_pkg::CENTER_RST;
    end else if (adv_i && valid_i) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== rtl/four_servo_slew_limited_steering_top.sv =====
// Top level of the four-servo slew-limited steering block.
`timescale 1ns / 1ps

// Takes one control tick per clock unless the result side stalls, and returns the four
// servo positions for that tick through the input, conditioning, filter and position
// registers. Ticks may follow back to back, since the filter and position registers each
// compute the next value combinationally. A result-side stall holds the whole pipeline.
// Configuration is through the APB port at byte address 4*i for register i.

module four_servo_slew_limited_steering_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [15:0]          speed_loop_out_i,
  input  logic signed [15:0]          angle_loop_out_i,
  input  logic                        angle_boost_i,
  input  logic                        jump_active_i,
  input  logic                        run_active_i,
  input  logic                        hold_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [13:0]                 position_a_o,
  output logic [13:0]                 position_b_o,
  output logic [13:0]                 position_c_o,
  output logic [13:0]                 position_d_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fssl_pkg::ADDR_W-1:0] paddr,
  input  logic [fssl_pkg::DATA_W-1:0] pwdata,
  output logic [fssl_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  fssl_pkg::cfg_t    cfg;
  logic              adv;
  logic              v0_q, v1_q, v2_q, v3_q, out_valid_q;
  fssl_pkg::in_t     spd_q;
  fssl_pkg::in_t     ang_q;
  logic              boost_q;
  fssl_pkg::mode_t   mode0_q, mode1_q, mode2_q, mode3_q;
  fssl_pkg::duty_t   duty;
  fssl_pkg::angmag_t neg2;
  fssl_pkg::angmag_t pos2;
  fssl_pkg::angmag_t neg3_q;
  fssl_pkg::angmag_t pos3_q;
  fssl_pkg::filt_t   filt;
  fssl_pkg::pos_t    pos [fssl_pkg::NSERVO];

  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;

  fssl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spd_q        <= speed_loop_out_i;
      ang_q        <= angle_loop_out_i;
      boost_q      <= angle_boost_i;
      mode0_q.run  <= run_active_i;
      mode0_q.jump <= jump_active_i;
      mode0_q.hold <= hold_i;
      mode1_q      <= mode0_q;
      mode2_q      <= mode1_q;
      mode3_q      <= mode2_q;
      neg3_q       <= neg2;
      pos3_q       <= pos2;
    end
  end

  fssl_cond u_cond (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .spd_i        (spd_q),
    .ang_i        (ang_q),
    .boost_i      (boost_q),
    .jump_i       (mode0_q.jump),
    .speed_gain_i (cfg.speed_gain),
    .boost_gain_i (cfg.boost_gain),
    .duty_o       (duty),
    .neg_o        (neg2),
    .pos_o        (pos2)
  );

  fssl_filt u_filt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v2_q),
    .duty_i  (duty),
    .filt_o  (filt)
  );

  for (genvar i = 0; i < fssl_pkg::NSERVO; i++) begin : g_servo
    fssl_servo u_servo (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (v3_q),
      .mode_i  (mode3_q),
      .filt_i  (filt),
      .neg_f_i (1'(i / 2)),
      .k_i     (((i % 2) == 0) ? neg3_q : pos3_q),
      .ctr_i   (cfg.center[i]),
      .dir_i   (cfg.dir_mask[i]),
      .pos_o   (pos[i])
    );
  end

  assign position_a_o = pos[0];
  assign position_b_o = pos[1];
  assign position_c_o = pos[2];
  assign position_d_o = pos[3];

endmodule

// ===== rtl/fssl_checker.sv =====
// Port-level checker for the steering block and its bind to the top level.
`timescale 1ns / 1ps

module fssl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [13:0] position_a_o,
  input logic [13:0] position_b_o,
  input logic [13:0] position_c_o,
  input logic [13:0] position_d_o
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(position_a_o) &&
      $stable(position_b_o) && $stable(position_c_o) && $stable(position_d_o))
    else $error("stalled result beat changed");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output side is free");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      position_a_o >= fssl_pkg::POSITION_MIN && position_a_o <= fssl_pkg::POSITION_MAX &&
      position_b_o >= fssl_pkg::POSITION_MIN && position_b_o <= fssl_pkg::POSITION_MAX &&
      position_c_o >= fssl_pkg::POSITION_MIN && position_c_o <= fssl_pkg::POSITION_MAX &&
      position_d_o >= fssl_pkg::POSITION_MIN && position_d_o <= fssl_pkg::POSITION_MAX)
    else $error("servo position outside limits");

endmodule

bind four_servo_slew_limited_steering_top fssl_checker u_fssl_checker (.*);
